// ===== design/hsme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsme_pkg: shared definitions of the hierarchical state machine engine
// Holds the sizes, operation, status and notice codes, the sequencer states
// and the layout of one entry of the transition store.
// ----------------------------------------------------------------------------
package hsme_pkg;

	localparam int NUM_STATES      = 16;
	localparam int MAX_TRANSITIONS = 64;
	localparam int EVENT_BITS      = 8;
	localparam int SW              = $clog2(NUM_STATES);
	localparam int TW              = $clog2(MAX_TRANSITIONS);

	localparam logic [2:0] OP_ADD_STATE = 3'd0;
	localparam logic [2:0] OP_ADD_TRANS = 3'd1;
	localparam logic [2:0] OP_START     = 3'd2;
	localparam logic [2:0] OP_STOP      = 3'd3;
	localparam logic [2:0] OP_POST      = 3'd4;
	localparam logic [2:0] OP_QUERY     = 3'd5;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_RUNNING     = 4'd1;
	localparam logic [3:0] ST_DUPLICATE   = 4'd2;
	localparam logic [3:0] ST_NO_PARENT   = 4'd3;
	localparam logic [3:0] ST_NO_STATE    = 4'd4;
	localparam logic [3:0] ST_SUPER_TGT   = 4'd5;
	localparam logic [3:0] ST_TABLE_FULL  = 4'd6;
	localparam logic [3:0] ST_NOT_RUNNING = 4'd7;
	localparam logic [3:0] ST_NO_INITIAL  = 4'd8;
	localparam logic [3:0] ST_NO_TRANS    = 4'd9;
	localparam logic [3:0] ST_BAD_STATE   = 4'd10;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_EXIT   = 2'd1;
	localparam logic [1:0] KIND_ENTRY  = 2'd2;

	localparam logic       REG_INITIAL = 1'b0;
	localparam logic       REG_FINAL   = 1'b1;

	localparam logic signed [4:0] NO_STATE = -5'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCMP, S_DEC, S_NCH, S_OCH, S_EXIT, S_ENTRY,
		S_SELFX, S_SELFN, S_QUERY, S_STATUS
	} seq_state_t;

	typedef struct packed {
		logic [SW-1:0]         src;
		logic [EVENT_BITS-1:0] ev;
		logic [SW-1:0]         tgt;
	} trans_t;

endpackage

// ===== design/hsme_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsme request and response channels
// Valid/ready channels carrying command beats in and result beats out; last marks a command's final result beat.
// ----------------------------------------------------------------------------
interface hsme_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        op;
	logic [3:0]        state_id;
	logic signed [4:0] parent_state;
	logic [7:0]        event_code;
	logic [3:0]        target_state;
	modport source (output valid, op, state_id, parent_state, event_code, target_state,
		input ready);
	modport sink (input valid, op, state_id, parent_state, event_code, target_state,
		output ready);
endinterface

interface hsme_rsp_if;
	logic              valid;
	logic              ready;
	logic [1:0]        result_kind;
	logic signed [4:0] state_num;
	logic [3:0]        status;
	logic signed [4:0] current_state;
	logic              running;
	logic              in_state_hit;
	logic              last;
	modport source (output valid, result_kind, state_num, status, current_state, running,
		in_state_hit, last, input ready);
	modport sink (input valid, result_kind, state_num, status, current_state, running,
		in_state_hit, last, output ready);
endinterface

// ===== design/hsme_tstore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsme_tstore: transition store
// One write port and one registered read port over the transition entries.
// ----------------------------------------------------------------------------
module hsme_tstore (
	input  logic                 clk,
	input  logic                 we,
	input  logic [hsme_pkg::TW-1:0] waddr,
	input  hsme_pkg::trans_t     wdata,
	input  logic [hsme_pkg::TW-1:0] raddr,
	output hsme_pkg::trans_t     rdata
);
	import hsme_pkg::*;

	trans_t mem_q [MAX_TRANSITIONS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/hierarchical_state_machine_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hierarchical state machine engine
// Holds a programmable state hierarchy and transition table and walks it.
// ----------------------------------------------------------------------------
// Each command beat is handled by a small sequencer, one command at a time;
// req.ready is high only while the engine is idle. Build and stop commands
// send only the status beat, and start sends an entry beat and then the status
// beat; each beat waits while the receiver stalls. A posted event reads the
// transition store one entry at a time for each level from the current leaf
// up to the matching ancestor, stepping to the parent once a level's entries
// are used up. A move to another state then walks the new and old parent
// chains once each, and walks the old chain and the stacked new chain once
// more, sending an exit or entry notice on the levels that change, before the
// closing status beat; a move to the current state sends its exit and entry
// notices. A query walks the chain one level per cycle. The transition store
// has a single read port, and the parent table is read through a single walk
// pointer. The current_state and running fields of every beat of a command
// already show the state after that command.
module hierarchical_state_machine_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [4:0] cfg_wdata,
	hsme_req_if.sink   req,
	hsme_rsp_if.source rsp
);
	import hsme_pkg::*;

	seq_state_t st_q, st_d;

	// Configuration and architectural state.
	logic signed [4:0] init_q, fin_q;
	logic [NUM_STATES-1:0] def_q, hc_q;
	logic signed [4:0] par_q [NUM_STATES];
	logic [TW:0] count_q;
	logic signed [4:0] cur_q;
	logic run_q;

	// Per-command working registers.
	logic [3:0] sid_q, dest_q, stat_q;
	logic [EVENT_BITS-1:0] ev_q;
	logic hit_q;
	logic [TW:0] idx_q;
	logic signed [4:0] walk_q, oldcur_q;
	logic [NUM_STATES-1:0] nmask_q, omask_q;
	logic [SW-1:0] stack_q [NUM_STATES];
	logic [SW:0] nn_q;

	// Output register.
	logic ov_q, last_q, ohit_q, orun_q;
	logic [1:0] okind_q;
	logic signed [4:0] onum_q, ocur_q;
	logic [3:0] ostat_q;

	trans_t rdata;
	trans_t wentry;
	logic tw_en;

	logic par_known, init_known, walk_known, can_emit, emit_req, fire;
	logic [3:0] idle_stat;
	logic [1:0] emit_kind;
	logic signed [4:0] emit_num;
	logic [SW-1:0] ent_s;

	assign par_known  = !req.parent_state[4] && def_q[req.parent_state[3:0]];
	assign init_known = !init_q[4] && def_q[init_q[3:0]];
	assign walk_known = !walk_q[4] && def_q[walk_q[3:0]];
	assign ent_s      = stack_q[SW'(nn_q - 1'b1)];
	assign can_emit   = !ov_q || rsp.ready;
	assign fire       = emit_req && can_emit;
	assign req.ready  = (st_q == S_IDLE);

	// Status of the commands that are decided in the accepting cycle.
	always_comb begin
		idle_stat = ST_OK;
		case (req.op)
			OP_ADD_STATE: begin
				if (run_q) idle_stat = ST_RUNNING;
				else if (def_q[req.state_id]) idle_stat = ST_DUPLICATE;
				else if (req.parent_state != NO_STATE && !par_known) idle_stat = ST_NO_PARENT;
			end
			OP_ADD_TRANS: begin
				if (run_q) idle_stat = ST_RUNNING;
				else if (!def_q[req.state_id] || !def_q[req.target_state])
					idle_stat = ST_NO_STATE;
				else if (hc_q[req.target_state]) idle_stat = ST_SUPER_TGT;
				else if (count_q[TW]) idle_stat = ST_TABLE_FULL;
			end
			OP_START: begin
				if (run_q) idle_stat = ST_RUNNING;
				else if (init_q == NO_STATE) idle_stat = ST_NO_INITIAL;
				else if (!init_known) idle_stat = ST_BAD_STATE;
			end
			OP_STOP, OP_POST, OP_QUERY: begin
				if (!run_q) idle_stat = ST_NOT_RUNNING;
			end
			default: idle_stat = ST_OK;
		endcase
	end

	assign tw_en      = req.valid && req.ready && req.op == OP_ADD_TRANS && idle_stat == ST_OK;
	assign wentry.src = req.state_id;
	assign wentry.ev  = req.event_code[EVENT_BITS-1:0];
	assign wentry.tgt = req.target_state;

	hsme_tstore u_tstore (
		.clk   (clk),
		.we    (tw_en),
		.waddr (count_q[TW-1:0]),
		.wdata (wentry),
		.raddr (idx_q[TW-1:0]),
		.rdata (rdata)
	);

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (req.valid) begin
					if (idle_stat != ST_OK) st_d = S_STATUS;
					else if (req.op == OP_START) st_d = S_SELFN;
					else if (req.op == OP_POST) st_d = S_SRD;
					else if (req.op == OP_QUERY) st_d = S_QUERY;
					else st_d = S_STATUS;
				end
			end
			S_SRD: begin
				if (idx_q < count_q) st_d = S_SCMP;
				else if (!(!par_q[walk_q[3:0]][4] && def_q[par_q[walk_q[3:0]][3:0]]) ||
					!walk_known)
					st_d = S_STATUS;
			end
			S_SCMP: begin
				if (rdata.src == walk_q[3:0] && rdata.ev == ev_q) st_d = S_DEC;
				else st_d = S_SRD;
			end
			S_DEC: begin
				if (!def_q[dest_q]) st_d = S_STATUS;
				else if ({1'b0, dest_q} == oldcur_q) st_d = S_SELFX;
				else if (hc_q[dest_q]) st_d = S_STATUS;
				else st_d = S_NCH;
			end
			S_NCH: if (!walk_known) st_d = S_OCH;
			S_OCH: if (!walk_known) st_d = S_EXIT;
			S_EXIT: if (!walk_known) st_d = S_ENTRY;
			S_ENTRY: if (nn_q == '0) st_d = S_STATUS;
			S_SELFX: if (fire) st_d = S_SELFN;
			S_SELFN: if (fire) st_d = S_STATUS;
			S_QUERY: begin
				if (!walk_known || walk_q[3:0] == sid_q) st_d = S_STATUS;
			end
			S_STATUS: if (fire) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// Beat to emit in the current state.
	always_comb begin
		emit_req  = 1'b0;
		emit_kind = KIND_STATUS;
		emit_num  = NO_STATE;
		case (st_q)
			S_EXIT: begin
				emit_req  = walk_known && !nmask_q[walk_q[3:0]];
				emit_kind = KIND_EXIT;
				emit_num  = walk_q;
			end
			S_ENTRY: begin
				emit_req  = nn_q != '0 && !omask_q[ent_s];
				emit_kind = KIND_ENTRY;
				emit_num  = {1'b0, ent_s};
			end
			S_SELFX: begin
				emit_req  = 1'b1;
				emit_kind = KIND_EXIT;
				emit_num  = {1'b0, dest_q};
			end
			S_SELFN: begin
				emit_req  = 1'b1;
				emit_kind = KIND_ENTRY;
				emit_num  = {1'b0, dest_q};
			end
			S_STATUS: emit_req = 1'b1;
			default: emit_req = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			init_q  <= NO_STATE;
			fin_q   <= NO_STATE;
			def_q   <= '0;
			hc_q    <= '0;
			count_q <= '0;
			cur_q   <= NO_STATE;
			run_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_idx == REG_INITIAL) init_q <= cfg_wdata;
				else fin_q <= cfg_wdata;
			end
			if (fire) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (req.valid && idle_stat == ST_OK) begin
						case (req.op)
							OP_ADD_STATE: begin
								// A state that is not yet defined has no children.
								if (req.parent_state != NO_STATE)
									hc_q[req.parent_state[3:0]] <= 1'b1;
								def_q[req.state_id] <= 1'b1;
							end
							OP_ADD_TRANS: count_q <= count_q + 1'b1;
							OP_START: begin
								cur_q <= init_q;
								run_q <= 1'b1;
							end
							OP_STOP: begin
								cur_q <= NO_STATE;
								run_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_DEC: begin
					// The outcome is committed before any notice leaves.
					if (def_q[dest_q] && ({1'b0, dest_q} == oldcur_q || !hc_q[dest_q])) begin
						if ({1'b0, dest_q} == fin_q) begin
							cur_q <= NO_STATE;
							run_q <= 1'b0;
						end else begin
							cur_q <= {1'b0, dest_q};
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers and the output register payload.
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && req.valid) begin
			sid_q    <= req.state_id;
			ev_q     <= req.event_code[EVENT_BITS-1:0];
			stat_q   <= idle_stat;
			hit_q    <= 1'b0;
			idx_q    <= '0;
			walk_q   <= cur_q;
			oldcur_q <= cur_q;
			dest_q   <= init_q[3:0];
			if (req.op == OP_ADD_STATE && idle_stat == ST_OK)
				par_q[req.state_id] <= req.parent_state;
		end
		case (st_q)
			S_SRD: begin
				if (!(idx_q < count_q)) begin
					idx_q  <= '0;
					walk_q <= par_q[walk_q[3:0]];
					if (!(!par_q[walk_q[3:0]][4] && def_q[par_q[walk_q[3:0]][3:0]]) ||
						!walk_known)
						stat_q <= ST_NO_TRANS;
				end
			end
			S_SCMP: begin
				dest_q <= rdata.tgt;
				idx_q  <= idx_q + 1'b1;
			end
			S_DEC: begin
				if (!def_q[dest_q]) stat_q <= ST_NO_TRANS;
				else if ({1'b0, dest_q} != oldcur_q && hc_q[dest_q]) stat_q <= ST_SUPER_TGT;
				walk_q  <= {1'b0, dest_q};
				nmask_q <= '0;
				omask_q <= '0;
				nn_q    <= '0;
			end
			S_NCH: begin
				if (walk_known) begin
					stack_q[nn_q[SW-1:0]] <= walk_q[3:0];
					nmask_q[walk_q[3:0]]  <= 1'b1;
					nn_q   <= nn_q + 1'b1;
					walk_q <= par_q[walk_q[3:0]];
				end else begin
					walk_q <= oldcur_q;
				end
			end
			S_OCH: begin
				if (walk_known) begin
					omask_q[walk_q[3:0]] <= 1'b1;
					walk_q <= par_q[walk_q[3:0]];
				end else begin
					walk_q <= oldcur_q;
				end
			end
			S_EXIT: begin
				if (walk_known && (!emit_req || fire)) walk_q <= par_q[walk_q[3:0]];
			end
			S_ENTRY: begin
				if (nn_q != '0 && (!emit_req || fire)) nn_q <= nn_q - 1'b1;
			end
			S_QUERY: begin
				if (walk_known) begin
					if (walk_q[3:0] == sid_q) hit_q <= 1'b1;
					else walk_q <= par_q[walk_q[3:0]];
				end
			end
			default: ;
		endcase
		// The run state is captured with the beat, so a beat that waits for the
		// receiver keeps its own command's view while the next one is taken.
		if (fire) begin
			okind_q <= emit_kind;
			onum_q  <= emit_num;
			ostat_q <= (st_q == S_STATUS) ? stat_q : ST_OK;
			ohit_q  <= (st_q == S_STATUS) ? hit_q : 1'b0;
			last_q  <= (st_q == S_STATUS);
			ocur_q  <= cur_q;
			orun_q  <= run_q;
		end
	end

	assign rsp.valid         = ov_q;
	assign rsp.result_kind   = okind_q;
	assign rsp.state_num     = onum_q;
	assign rsp.status        = ostat_q;
	assign rsp.current_state = ocur_q;
	assign rsp.running       = orun_q;
	assign rsp.in_state_hit  = ohit_q;
	assign rsp.last          = last_q;
endmodule
